@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge
`define SHL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// check a consequent in the same cycle
`define SHL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check a consequent in the next cycle
`define SHL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/shl_pkg.sv @@
package shl_pkg;

  localparam int unsigned MAX_LEN   = 4096;
  localparam int unsigned AW        = $clog2(MAX_LEN + 1);
  localparam int unsigned PW        = 13;
  localparam int unsigned HW        = 30;
  localparam int unsigned RW        = HW + 2;
  localparam int unsigned MUL_STEPS = HW / 2;
  localparam int unsigned CW        = $clog2(MUL_STEPS);

  localparam logic [HW-1:0] MOD_ONE   = 30'd998244353;
  localparam logic [HW-1:0] MOD_TWO   = 30'd1000000007;
  localparam logic [HW-1:0] HASH_BASE = 30'd443;
  localparam logic [PW-1:0] LEN_CAP   = PW'(MAX_LEN);

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_HASH  = 3'd1,
    REQ_EQUAL = 3'd2,
    REQ_LCP   = 3'd3,
    REQ_LCS   = 3'd4
  } shl_req_e;

  typedef enum logic [3:0] {
    S_FILL_WRITE,
    S_FILL_WAIT,
    S_IDLE,
    S_DISPATCH,
    S_LD_PREP,
    S_LD_READ,
    S_LD_MUL,
    S_LD_WAIT,
    S_RH_ADDR,
    S_RH_MUL,
    S_RH_CAPT,
    S_RH_WAIT,
    S_RH_NEXT,
    S_BS_STEP,
    S_BS_CHECK
  } shl_state_e;

  typedef enum logic [1:0] {
    RNG_FIRST,
    RNG_SECOND,
    RNG_PROBE_X,
    RNG_PROBE_Y
  } shl_rng_e;

  typedef enum logic [1:0] {
    RD_LEN,
    RD_LEFT,
    RD_RIGHT
  } shl_rd_e;

  typedef enum logic [1:0] {
    SRC_FILL,
    SRC_LOAD,
    SRC_RANGE
  } shl_src_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_BAD,
    RES_HASH,
    RES_EQUAL,
    RES_LEN_LO,
    RES_LEN_DIRECT
  } shl_res_e;

  typedef struct packed {
    logic [2:0]    req_type;
    logic          start_new;
    logic [7:0]    symbol;
    logic [PW-1:0] first_left;
    logic [PW-1:0] first_right;
    logic [PW-1:0] second_left;
    logic [PW-1:0] second_right;
  } shl_req_t;

  typedef struct packed {
    logic [59:0]   hash_value;
    logic          ranges_equal;
    logic [PW-1:0] match_length;
    logic          out_of_range;
  } shl_result_t;

  typedef struct packed {
    logic     latch;
    logic     ld_prep;
    logic     ld_write;
    logic     fill_write;
    logic     fill_next;
    logic     mul_start;
    shl_src_e mul_src;
    shl_rd_e  rd_sel;
    shl_rng_e rng;
    logic     capt_right;
    logic     store_slot;
    logic     bs_init;
    logic     mid_set;
    logic     bs_update;
    logic     finish;
    shl_res_e res_kind;
  } shl_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       mul_done;
    logic       len_full;
    logic       empty1;
    logic       empty2;
    logic       bad1;
    logic       bad2;
    logic       pos_bad;
    logic       pos_same;
    logic       bs_more;
    logic       fill_last;
  } shl_sts_t;

endpackage

@@ sv/shl_modmul.sv @@
module shl_modmul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [shl_pkg::HW-1:0] a_i,
  input  logic [shl_pkg::HW-1:0] b_i,
  input  logic [shl_pkg::HW-1:0] mod_i,
  output logic                   done_o,
  output logic [shl_pkg::HW-1:0] prod_o
);
  import shl_pkg::*;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] acc_q, acc_d;
  logic [HW-1:0] a_q, b_q, b_d;

  always_comb begin
    acc_d = acc_q;
    b_d   = b_q;
    for (int k = 0; k < 2; k++) begin
      acc_d = {acc_d[RW-2:0], 1'b0} + (b_d[HW-1] ? {2'b00, a_q} : '0);
      if (acc_d >= {2'b00, mod_i}) acc_d = acc_d - {2'b00, mod_i};
      if (acc_d >= {2'b00, mod_i}) acc_d = acc_d - {2'b00, mod_i};
      b_d = {b_d[HW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[HW-1:0];

endmodule

@@ sv/shl_datapath.sv @@
`include "assert_macros.svh"

module shl_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  shl_pkg::shl_req_t    req_i,
  input  shl_pkg::shl_cmd_t    cmd_i,
  output shl_pkg::shl_sts_t    sts_o,
  output shl_pkg::shl_result_t res_o,
  output logic                 valid_o
);
  import shl_pkg::*;

  shl_req_t      req_q;
  shl_result_t   res_q, res_d;
  logic          valid_q;
  logic [PW-1:0] len_q, lo_q, hi_q, mid_q, fill_idx_q;
  logic [HW-1:0] pacc1_q, pacc2_q;

  logic [HW-1:0] ph1_mem [0:MAX_LEN];
  logic [HW-1:0] ph2_mem [0:MAX_LEN];
  logic [HW-1:0] pw1_mem [0:MAX_LEN];
  logic [HW-1:0] pw2_mem [0:MAX_LEN];

  logic [HW-1:0] ph1_rd_q, ph2_rd_q, pw1_rd_q, pw2_rd_q;
  logic          phz_q;
  logic [HW-1:0] phr1_q, phr2_q;
  logic [HW-1:0] h1_q [2];
  logic [HW-1:0] h2_q [2];

  logic [PW-1:0] x, y, lft, rgt, span, big, smal;
  logic [AW-1:0] ph_raddr, pw_raddr;
  logic          lcp, empty1, empty2, bad1, bad2, same, slot;
  logic [HW-1:0] a1, a2, b1, b2, prod1, prod2, ph1_m, ph2_m;
  logic          done1, done2;
  logic [HW:0]   sub1, sub2, lv1, lv2;
  logic [HW-1:0] rh1, rh2, ld1, ld2;
  logic [59:0]   hv;
  logic [PW:0]   lohi;

  assign x    = req_q.first_left;
  assign y    = req_q.second_left;
  assign lcp  = (req_q.req_type == REQ_LCP);
  assign big  = (x > y) ? x : y;
  assign smal = (x < y) ? x : y;

  always_comb begin
    unique case (cmd_i.rng)
      RNG_FIRST: begin
        lft = req_q.first_left;
        rgt = req_q.first_right;
      end
      RNG_SECOND: begin
        lft = req_q.second_left;
        rgt = req_q.second_right;
      end
      RNG_PROBE_X: begin
        lft = lcp ? x : x - mid_q + 1'b1;
        rgt = lcp ? x + mid_q - 1'b1 : x;
      end
      RNG_PROBE_Y: begin
        lft = lcp ? y : y - mid_q + 1'b1;
        rgt = lcp ? y + mid_q - 1'b1 : y;
      end
      default: begin
        lft = req_q.first_left;
        rgt = req_q.first_right;
      end
    endcase
  end

  assign span     = rgt - lft + 1'b1;
  assign pw_raddr = AW'(span);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_LEN:   ph_raddr = AW'(len_q);
      RD_LEFT:  ph_raddr = AW'(lft - 1'b1);
      RD_RIGHT: ph_raddr = AW'(rgt);
      default:  ph_raddr = AW'(len_q);
    endcase
  end

  assign empty1 = req_q.first_left > req_q.first_right;
  assign empty2 = req_q.second_left > req_q.second_right;
  assign bad1   = !empty1 && (req_q.first_left == '0 || req_q.first_right > len_q);
  assign bad2   = !empty2 && (req_q.second_left == '0 || req_q.second_right > len_q);
  assign same   = (h1_q[0] == h1_q[1]) && (h2_q[0] == h2_q[1]);
  assign slot   = (cmd_i.rng == RNG_SECOND) || (cmd_i.rng == RNG_PROBE_Y);
  assign lohi   = {1'b0, lo_q} + {1'b0, hi_q};

  assign ph1_m = phz_q ? '0 : ph1_rd_q;
  assign ph2_m = phz_q ? '0 : ph2_rd_q;

  always_comb begin
    unique case (cmd_i.mul_src)
      SRC_FILL: begin
        a1 = pacc1_q;
        a2 = pacc2_q;
        b1 = HASH_BASE;
        b2 = HASH_BASE;
      end
      SRC_RANGE: begin
        a1 = ph1_m;
        a2 = ph2_m;
        b1 = pw1_rd_q;
        b2 = pw2_rd_q;
      end
      default: begin
        a1 = ph1_m;
        a2 = ph2_m;
        b1 = HASH_BASE;
        b2 = HASH_BASE;
      end
    endcase
  end

  shl_modmul u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (a1),
    .b_i     (b1),
    .mod_i   (MOD_ONE),
    .done_o  (done1),
    .prod_o  (prod1)
  );

  shl_modmul u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (a2),
    .b_i     (b2),
    .mod_i   (MOD_TWO),
    .done_o  (done2),
    .prod_o  (prod2)
  );

  always_comb begin
    sub1 = {1'b0, phr1_q} + {1'b0, MOD_ONE} - {1'b0, prod1};
    sub2 = {1'b0, phr2_q} + {1'b0, MOD_TWO} - {1'b0, prod2};
    lv1  = {1'b0, prod1} + (HW+1)'(req_q.symbol);
    lv2  = {1'b0, prod2} + (HW+1)'(req_q.symbol);
    rh1  = (sub1 >= {1'b0, MOD_ONE}) ? HW'(sub1 - {1'b0, MOD_ONE}) : sub1[HW-1:0];
    rh2  = (sub2 >= {1'b0, MOD_TWO}) ? HW'(sub2 - {1'b0, MOD_TWO}) : sub2[HW-1:0];
    ld1  = (lv1 >= {1'b0, MOD_ONE}) ? HW'(lv1 - {1'b0, MOD_ONE}) : lv1[HW-1:0];
    ld2  = (lv2 >= {1'b0, MOD_TWO}) ? HW'(lv2 - {1'b0, MOD_TWO}) : lv2[HW-1:0];
    hv   = 60'(h1_q[0]) * 60'(MOD_TWO) + 60'(h2_q[0]) + 60'd1;
  end

  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      RES_BAD:   res_d.out_of_range = 1'b1;
      RES_HASH:  res_d.hash_value = hv;
      RES_EQUAL: res_d.ranges_equal = (empty1 && empty2) || (!empty1 && !empty2 && same);
      RES_LEN_LO: res_d.match_length = lo_q;
      RES_LEN_DIRECT: res_d.match_length = lcp ? len_q - x + 1'b1 : x;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      fill_idx_q <= '0;
      pacc1_q    <= HW'(1);
      pacc2_q    <= HW'(1);
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cmd_i.ld_prep && req_q.start_new) len_q <= '0;
      else if (cmd_i.ld_write) len_q <= len_q + 1'b1;
      if (cmd_i.fill_next) begin
        fill_idx_q <= fill_idx_q + 1'b1;
        pacc1_q    <= prod1;
        pacc2_q    <= prod2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_write) begin
      ph1_mem[AW'(len_q + 1'b1)] <= ld1;
      ph2_mem[AW'(len_q + 1'b1)] <= ld2;
    end
    ph1_rd_q <= ph1_mem[ph_raddr];
    ph2_rd_q <= ph2_mem[ph_raddr];
    phz_q    <= (ph_raddr == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_write) begin
      pw1_mem[AW'(fill_idx_q)] <= pacc1_q;
      pw2_mem[AW'(fill_idx_q)] <= pacc2_q;
    end
    pw1_rd_q <= pw1_mem[pw_raddr];
    pw2_rd_q <= pw2_mem[pw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) req_q <= req_i;
    if (cmd_i.capt_right) begin
      phr1_q <= ph1_rd_q;
      phr2_q <= ph2_rd_q;
    end
    if (cmd_i.store_slot) begin
      h1_q[slot] <= rh1;
      h2_q[slot] <= rh2;
    end
    if (cmd_i.bs_init) begin
      lo_q <= '0;
      hi_q <= lcp ? len_q - big + PW'(2) : smal + 1'b1;
    end else if (cmd_i.bs_update) begin
      if (same) lo_q <= mid_q;
      else      hi_q <= mid_q;
    end
    if (cmd_i.mid_set) mid_q <= lohi[PW:1];
    if (cmd_i.finish) res_q <= res_d;
  end

  always_comb begin
    sts_o.req_type  = req_q.req_type;
    sts_o.mul_done  = done1;
    sts_o.len_full  = (len_q == LEN_CAP);
    sts_o.empty1    = empty1;
    sts_o.empty2    = empty2;
    sts_o.bad1      = bad1;
    sts_o.bad2      = bad2;
    sts_o.pos_bad   = (x == '0) || (x > len_q) || (y == '0) || (y > len_q);
    sts_o.pos_same  = (x == y);
    sts_o.bs_more   = ({1'b0, lo_q} + 1'b1) < {1'b0, hi_q};
    sts_o.fill_last = (fill_idx_q == LEN_CAP);
  end

  assign res_o   = res_q;
  assign valid_o = valid_q;

  `SHL_ASSERT_ALWAYS(a_len_cap, len_q <= LEN_CAP, "string length past capacity")
  `SHL_ASSERT_ALWAYS(a_mul_pair, done1 == done2, "hash multipliers out of step")
  `SHL_ASSERT_NEXT(a_valid_pulse, valid_q, !valid_q, "result strobe held two cycles")

endmodule

@@ sv/shl_ctrl.sv @@
`include "assert_macros.svh"

module shl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  shl_pkg::shl_sts_t sts_i,
  output shl_pkg::shl_cmd_t cmd_o
);
  import shl_pkg::*;

  shl_state_e state_q, state_d;
  shl_rng_e   rng_q, rng_d;
  logic       in_wait;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL_WRITE;
      rng_q   <= RNG_FIRST;
    end else begin
      state_q <= state_d;
      rng_q   <= rng_d;
    end
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.rng = rng_q;
    state_d   = state_q;
    rng_d     = rng_q;
    unique case (state_q)
      S_FILL_WRITE: begin
        cmd_o.fill_write = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_src   = SRC_FILL;
          state_d         = S_FILL_WAIT;
        end
      end
      S_FILL_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.fill_next = 1'b1;
          state_d         = S_FILL_WRITE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.req_type) inside
          REQ_LOAD: state_d = S_LD_PREP;
          REQ_HASH: begin
            if (sts_i.empty1 || sts_i.bad1) begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = sts_i.bad1 ? RES_BAD : RES_ZERO;
              state_d        = S_IDLE;
            end else begin
              rng_d   = RNG_FIRST;
              state_d = S_RH_ADDR;
            end
          end
          REQ_EQUAL: begin
            if (sts_i.bad1 || sts_i.bad2) begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = RES_BAD;
              state_d        = S_IDLE;
            end else if (!sts_i.empty1 && !sts_i.empty2) begin
              rng_d   = RNG_FIRST;
              state_d = S_RH_ADDR;
            end else begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = RES_EQUAL;
              state_d        = S_IDLE;
            end
          end
          REQ_LCP, REQ_LCS: begin
            if (sts_i.pos_bad || sts_i.pos_same) begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = sts_i.pos_bad ? RES_BAD : RES_LEN_DIRECT;
              state_d        = S_IDLE;
            end else begin
              cmd_o.bs_init = 1'b1;
              state_d       = S_BS_CHECK;
            end
          end
          default: begin
            cmd_o.finish   = 1'b1;
            cmd_o.res_kind = RES_ZERO;
            state_d        = S_IDLE;
          end
        endcase
      end
      S_LD_PREP: begin
        cmd_o.ld_prep = 1'b1;
        state_d       = S_LD_READ;
      end
      S_LD_READ: begin
        if (sts_i.len_full) begin
          cmd_o.finish   = 1'b1;
          cmd_o.res_kind = RES_BAD;
          state_d        = S_IDLE;
        end else begin
          cmd_o.rd_sel = RD_LEN;
          state_d      = S_LD_MUL;
        end
      end
      S_LD_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_src   = SRC_LOAD;
        state_d         = S_LD_WAIT;
      end
      S_LD_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.ld_write = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.res_kind = RES_ZERO;
          state_d        = S_IDLE;
        end
      end
      S_RH_ADDR: begin
        cmd_o.rd_sel = RD_LEFT;
        state_d      = S_RH_MUL;
      end
      S_RH_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_src   = SRC_RANGE;
        cmd_o.rd_sel    = RD_RIGHT;
        state_d         = S_RH_CAPT;
      end
      S_RH_CAPT: begin
        cmd_o.capt_right = 1'b1;
        state_d          = S_RH_WAIT;
      end
      S_RH_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.store_slot = 1'b1;
          state_d          = S_RH_NEXT;
        end
      end
      S_RH_NEXT: begin
        unique case (rng_q)
          RNG_FIRST: begin
            if (sts_i.req_type == REQ_EQUAL) begin
              rng_d   = RNG_SECOND;
              state_d = S_RH_ADDR;
            end else begin
              cmd_o.finish   = 1'b1;
              cmd_o.res_kind = RES_HASH;
              state_d        = S_IDLE;
            end
          end
          RNG_SECOND: begin
            cmd_o.finish   = 1'b1;
            cmd_o.res_kind = RES_EQUAL;
            state_d        = S_IDLE;
          end
          RNG_PROBE_X: begin
            rng_d   = RNG_PROBE_Y;
            state_d = S_RH_ADDR;
          end
          default: state_d = S_BS_STEP;
        endcase
      end
      S_BS_STEP: begin
        cmd_o.bs_update = 1'b1;
        state_d         = S_BS_CHECK;
      end
      S_BS_CHECK: begin
        if (sts_i.bs_more) begin
          cmd_o.mid_set = 1'b1;
          rng_d         = RNG_PROBE_X;
          state_d       = S_RH_ADDR;
        end else begin
          cmd_o.finish   = 1'b1;
          cmd_o.res_kind = RES_LEN_LO;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o  = (state_q != S_IDLE);
  assign in_wait = (state_q == S_FILL_WAIT) || (state_q == S_LD_WAIT) ||
                   (state_q == S_RH_WAIT);

  `SHL_ASSERT_IMP(a_done_in_wait, sts_i.mul_done, in_wait, "multiplier done outside a wait")
  `SHL_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted request did not raise busy")
  `SHL_ASSERT_IMP(a_finish_busy, cmd_o.finish, state_q != S_IDLE, "result issued from idle")

endmodule

@@ sv/substring_hash_lcp_engine_core.sv @@
// Load: after accept, the request passes the dispatch, prep, read, multiply and wait states before the result strobe.
// Range hash and equality: each non-empty range takes one run of the iterative multipliers.
// LCP and LCS: each binary-search probe hashes two ranges, up to 12 probes for a 4096-symbol string.
// One request at a time; busy holds until the one-cycle result strobe, which cannot be stalled.
// Reset clears the string and runs a power-table fill with busy high.
module substring_hash_lcp_engine_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  shl_pkg::shl_req_t    req_i,
  output shl_pkg::shl_result_t res_o,
  output logic                 valid_o
);
  import shl_pkg::*;

  shl_cmd_t cmd;
  shl_sts_t sts;

  shl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  shl_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .res_o   (res_o),
    .valid_o (valid_o)
  );

endmodule
